// ===== rtl/core/b2d_pkg.sv =====
package b2d_pkg;

   localparam int VALUE_W   = 63;
   localparam int DIGIT_W   = 4;
   localparam int POS_W     = 5;
   localparam int BIT_CNT_W = 6;

   // index of the final shift step (one step per input bit)
   localparam logic [BIT_CNT_W-1:0] LAST_BIT = BIT_CNT_W'(VALUE_W - 1);

   localparam logic [DIGIT_W-1:0] DIGIT_MAX = 4'd9;

   typedef logic [DIGIT_W-1:0] digit_type;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_CONV = 3'b010,
      ST_EMIT = 3'b100
   } state_type;

endpackage

// ===== rtl/core/b2d_dabble_step.sv =====
module b2d_dabble_step #(
   parameter int MAX_DIGITS = 19
) (
   input  logic [MAX_DIGITS-1:0][b2d_pkg::DIGIT_W-1:0] digits_in,
   input  logic                                        bit_in,
   output logic [MAX_DIGITS-1:0][b2d_pkg::DIGIT_W-1:0] digits_out,
   output logic                                        carry_out
);

   logic [MAX_DIGITS-1:0][b2d_pkg::DIGIT_W-1:0] adj;
   logic [MAX_DIGITS:0]                          carry;

   // add 3 to any digit of 5 or more, then shift the whole BCD word left by one
   always_comb begin
      carry[0] = bit_in;
      for (int i = 0; i < MAX_DIGITS; i++) begin
         if (digits_in[i] >= b2d_pkg::DIGIT_W'(5)) begin
            adj[i] = digits_in[i] + b2d_pkg::DIGIT_W'(3);
         end else begin
            adj[i] = digits_in[i];
         end
         digits_out[i] = {adj[i][b2d_pkg::DIGIT_W-2:0], carry[i]};
         carry[i+1]    = adj[i][b2d_pkg::DIGIT_W-1];
      end
      carry_out = carry[MAX_DIGITS];
   end

endmodule

// ===== rtl/core/binary_to_decimal_digits_top.sv =====
// Conversion: one shift-and-add-3 step per input bit, then one digit per cycle for count
// digits (count = top_digit_position + 1, saturated at MAX_DIGITS). A new transaction is
// accepted only once the previous run has ended; one shared double-dabble step unit.
// Results are one-cycle strobes; the receiver cannot stall them.
// Reset: synchronous, active high; clears the sequencer and the position register to 0.
module binary_to_decimal_digits_top #(
   parameter int MAX_DIGITS = 19
) (
   input  logic                                clock,
   input  logic                                reset,
   // input transaction
   input  logic                                start,
   output logic                                busy,
   input  logic [b2d_pkg::VALUE_W-1:0]         req_binary_value,
   // result strobe
   output logic                                rsp_valid,
   output logic [b2d_pkg::DIGIT_W-1:0]         rsp_decimal_digit,
   output logic                                rsp_last_digit,
   output logic                                rsp_overflow,
   // position register
   input  logic                                csr_wr_en,
   input  logic [b2d_pkg::POS_W-1:0]           csr_wr_data
);

   localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

   b2d_pkg::state_type state_ff, state_in;

   logic [b2d_pkg::POS_W-1:0]     cfg_ff, cfg_in;
   logic [b2d_pkg::VALUE_W-1:0]   shift_ff, shift_in;
   logic [b2d_pkg::BIT_CNT_W-1:0] bits_ff, bits_in;
   logic [MAX_DIGITS-1:0][b2d_pkg::DIGIT_W-1:0] bcd_ff, bcd_in;
   logic                          ovf_ff, ovf_in;
   logic [IDX_W-1:0]              top_idx_ff, top_idx_in;
   logic [IDX_W-1:0]              pos_ff, pos_in;

   // shared double-dabble step
   logic [MAX_DIGITS-1:0][b2d_pkg::DIGIT_W-1:0] step_digits;
   logic                                        step_carry;
   logic                                        high_nonzero;
   logic [IDX_W-1:0]                            cfg_idx;

   b2d_dabble_step #(
      .MAX_DIGITS (MAX_DIGITS)
   ) u_step (
      .digits_in  (bcd_ff),
      .bit_in     (shift_ff[b2d_pkg::VALUE_W-1]),
      .digits_out (step_digits),
      .carry_out  (step_carry)
   );

   // position register saturates to the widest supported digit count
   always_comb begin
      if (cfg_ff >= b2d_pkg::POS_W'(MAX_DIGITS - 1)) begin
         cfg_idx = IDX_W'(MAX_DIGITS - 1);
      end else begin
         cfg_idx = IDX_W'(cfg_ff);
      end
   end

   // any nonzero digit above the top emitted position means the value does not fit
   always_comb begin
      high_nonzero = 1'b0;
      for (int i = 0; i < MAX_DIGITS; i++) begin
         if ((i > int'(top_idx_ff)) && (step_digits[i] != '0)) begin
            high_nonzero = 1'b1;
         end
      end
   end

   assign cfg_in = csr_wr_en ? csr_wr_data : cfg_ff;

   always_comb begin
      state_in   = state_ff;
      shift_in   = shift_ff;
      bits_in    = bits_ff;
      bcd_in     = bcd_ff;
      ovf_in     = ovf_ff;
      top_idx_in = top_idx_ff;
      pos_in     = pos_ff;
      case (state_ff)
         b2d_pkg::ST_IDLE: begin
            if (start) begin
               shift_in   = req_binary_value;
               bits_in    = '0;
               bcd_in     = '0;
               ovf_in     = 1'b0;
               top_idx_in = cfg_idx;
               state_in   = b2d_pkg::ST_CONV;
            end
         end
         b2d_pkg::ST_CONV: begin
            // bits shifted out of the top digit are lost multiples of 10^MAX_DIGITS
            shift_in = {shift_ff[b2d_pkg::VALUE_W-2:0], 1'b0};
            bcd_in   = step_digits;
            ovf_in   = ovf_ff | step_carry;
            bits_in  = bits_ff + 1'b1;
            if (bits_ff == b2d_pkg::LAST_BIT) begin
               ovf_in   = ovf_ff | step_carry | high_nonzero;
               pos_in   = top_idx_ff;
               state_in = b2d_pkg::ST_EMIT;
            end
         end
         b2d_pkg::ST_EMIT: begin
            // most significant digit first, one per cycle
            pos_in = pos_ff - 1'b1;
            if (pos_ff == '0) begin
               state_in = b2d_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = b2d_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= b2d_pkg::ST_IDLE;
         cfg_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cfg_ff   <= cfg_in;
      end
   end

   // datapath registers, no reset needed
   always_ff @(posedge clock) begin
      shift_ff   <= shift_in;
      bits_ff    <= bits_in;
      bcd_ff     <= bcd_in;
      ovf_ff     <= ovf_in;
      top_idx_ff <= top_idx_in;
      pos_ff     <= pos_in;
   end

   assign busy              = (state_ff != b2d_pkg::ST_IDLE);
   assign rsp_valid         = (state_ff == b2d_pkg::ST_EMIT);
   assign rsp_decimal_digit = bcd_ff[pos_ff];
   assign rsp_last_digit    = (pos_ff == '0);
   assign rsp_overflow      = ovf_ff;

   // a run ends on its units digit and the block goes idle right after
   a_last_ends_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_digit |=> !busy)
      else $error("run did not end after units digit");

   // every emitted digit is a valid decimal digit
   a_digit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_decimal_digit <= b2d_pkg::DIGIT_MAX)
      else $error("digit out of range");

   // overflow flag holds across the whole run
   a_ovf_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && $past(rsp_valid) |-> $stable(rsp_overflow))
      else $error("overflow changed within a run");

   // an accepted transaction starts conversion, no result in the next cycle
   a_start_conv: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy && !rsp_valid)
      else $error("accepted transaction did not start conversion");

endmodule

// ===== tb/sv/binary_to_decimal_digits_checker.sv =====
`timescale 1ns / 1ps

// Watches both channels and the position register, predicts the digit run of
// every accepted transaction and compares each result strobe in order.
module binary_to_decimal_digits_checker #(
   parameter int MAX_DIGITS = 19
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          busy,
   input  logic [b2d_pkg::VALUE_W-1:0]   req_binary_value,
   input  logic                          rsp_valid,
   input  logic [b2d_pkg::DIGIT_W-1:0]   rsp_decimal_digit,
   input  logic                          rsp_last_digit,
   input  logic                          rsp_overflow,
   input  logic                          csr_wr_en,
   input  logic [b2d_pkg::POS_W-1:0]     csr_wr_data,
   output int                            error_count,
   output int                            digit_count,
   output int                            pending
);

   localparam int VALUE_W = b2d_pkg::VALUE_W;
   localparam int POS_W   = b2d_pkg::POS_W;

   typedef struct packed {
      b2d_pkg::digit_type digit;
      logic               last;
      logic               ovf;
   } digit_result_type;

   digit_result_type     expected_digits[$];
   logic [POS_W-1:0]     top_position;

   // Digits of value, most significant first, reduced modulo 10^count on overflow.
   function automatic void predict_digits(input logic [VALUE_W-1:0] value,
                                          input logic [POS_W-1:0] pos);
      logic [63:0]      remainder;
      logic [63:0]      scale;
      int               count;
      logic             ovf;
      digit_result_type entry;
      count = int'(pos) + 1;
      if (count > MAX_DIGITS)
         count = MAX_DIGITS;
      remainder = 64'(value);
      scale = 64'd1;
      repeat (count) scale = scale * 64'd10;   // 10^19 still fits in 64 bits
      ovf = (remainder >= scale);
      if (ovf)
         remainder = remainder % scale;
      for (int k = count - 1; k >= 0; k--) begin
         scale = scale / 64'd10;
         entry.digit = b2d_pkg::digit_type'(remainder / scale);
         entry.last  = (k == 0);
         entry.ovf   = ovf;
         remainder   = remainder % scale;
         expected_digits.push_back(entry);
      end
   endfunction

   always @(posedge clock) begin
      digit_result_type want;
      if (reset) begin
         top_position = '0;
         expected_digits.delete();
         error_count = 0;
         digit_count = 0;
      end else begin
         if (rsp_valid) begin
            digit_count++;
            if (expected_digits.size() == 0) begin
               $error("unexpected digit %0d (last %0b, overflow %0b)",
                      rsp_decimal_digit, rsp_last_digit, rsp_overflow);
               error_count++;
            end else begin
               want = expected_digits.pop_front();
               if (rsp_decimal_digit !== want.digit) begin
                  $error("decimal_digit: expected %0d, got %0d", want.digit, rsp_decimal_digit);
                  error_count++;
               end
               if (rsp_last_digit !== want.last) begin
                  $error("last_digit: expected %0b, got %0b", want.last, rsp_last_digit);
                  error_count++;
               end
               if (rsp_overflow !== want.ovf) begin
                  $error("overflow: expected %0b, got %0b", want.ovf, rsp_overflow);
                  error_count++;
               end
            end
         end
         if (csr_wr_en)
            top_position = csr_wr_data;
         if (start && !busy)
            predict_digits(req_binary_value, top_position);
      end
      pending = expected_digits.size();
   end

endmodule

// ===== tb/sv/binary_to_decimal_digits_top_tb.sv =====
`timescale 1ns / 1ps

// Stimulus and verdict for the binary to decimal digit splitter.
// All checking lives in the checker instance; this module only drives the
// request channel and the position register and reports the outcome.
module binary_to_decimal_digits_top_tb;

   localparam int VALUE_W    = b2d_pkg::VALUE_W;
   localparam int DIGIT_W    = b2d_pkg::DIGIT_W;
   localparam int POS_W      = b2d_pkg::POS_W;
   localparam int MAX_DIGITS = 19;
   localparam logic [VALUE_W-1:0] VALUE_ALL_ONES = '1;

   logic                clock = 1'b0;
   logic                reset;
   logic                start;
   logic                busy;
   logic [VALUE_W-1:0]  req_binary_value;
   logic                rsp_valid;
   logic [DIGIT_W-1:0]  rsp_decimal_digit;
   logic                rsp_last_digit;
   logic                rsp_overflow;
   logic                csr_wr_en;
   logic [POS_W-1:0]    csr_wr_data;

   int                  error_count;
   int                  digit_count;
   int                  pending;

   int                  values_sent;
   int                  settings_used;
   int                  cur_pos;        // position as last written, for stimulus shaping
   bit                  quiet_sender;   // back-to-back transactions, no idle gaps

   // 10 ns period
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   binary_to_decimal_digits_top #(
      .MAX_DIGITS(MAX_DIGITS)
   ) dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_binary_value  (req_binary_value),
      .rsp_valid         (rsp_valid),
      .rsp_decimal_digit (rsp_decimal_digit),
      .rsp_last_digit    (rsp_last_digit),
      .rsp_overflow      (rsp_overflow),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

   binary_to_decimal_digits_checker #(
      .MAX_DIGITS(MAX_DIGITS)
   ) digit_check (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_binary_value  (req_binary_value),
      .rsp_valid         (rsp_valid),
      .rsp_decimal_digit (rsp_decimal_digit),
      .rsp_last_digit    (rsp_last_digit),
      .rsp_overflow      (rsp_overflow),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .error_count       (error_count),
      .digit_count       (digit_count),
      .pending           (pending)
   );

   function automatic logic [63:0] ten_to(input int n);
      logic [63:0] p;
      p = 64'd1;
      repeat (n) p = p * 64'd10;
      return p;
   endfunction

   // Random value shaped around the current digit count: full range, values
   // that fit, values near 10^count or all-ones, and short random-width values.
   function automatic logic [VALUE_W-1:0] random_value();
      logic [63:0] wide;
      logic [63:0] limit;
      int          count;
      wide  = {$urandom(), $urandom()};
      count = (cur_pos + 1 > MAX_DIGITS) ? MAX_DIGITS : cur_pos + 1;
      limit = ten_to(count);
      case ($urandom_range(0, 3))
         0: return wide[VALUE_W-1:0];
         1: return VALUE_W'(wide % limit);
         2: begin
            if (count == MAX_DIGITS)
               return VALUE_ALL_ONES - VALUE_W'($urandom_range(0, 3));
            return VALUE_W'(limit - 64'd2 + 64'($urandom_range(0, 3)));
         end
         default: return wide[VALUE_W-1:0] >> $urandom_range(0, VALUE_W - 1);
      endcase
   endfunction

   // One request transaction. Entered and left at a falling edge; start stays
   // high on return so a zero gap gives true back-to-back requests.
   task automatic send_value(input logic [VALUE_W-1:0] value);
      int gap;
      gap = quiet_sender ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
         start = 1'b0;
         repeat (gap) @(negedge clock);
      end
      start = 1'b1;
      req_binary_value = value;
      // accepted at the first rising edge that sees busy low
      @(posedge clock);
      while (busy) @(posedge clock);
      @(negedge clock);
      values_sent++;
   endtask

   // Drain: every expected digit has come out and the block has dropped busy.
   task automatic wait_idle();
      start = 1'b0;
      do @(negedge clock); while (pending != 0 || busy);
      repeat (4) @(negedge clock);
   endtask

   // Position register write, only ever from an idle block.
   task automatic set_position(input int pos);
      wait_idle();
      csr_wr_en   = 1'b1;
      csr_wr_data = POS_W'(pos);
      cur_pos     = pos;
      @(negedge clock);
      csr_wr_en   = 1'b0;
      settings_used++;
   endtask

   initial begin
      int pos;
      start            = 1'b0;
      req_binary_value = '0;
      csr_wr_en        = 1'b0;
      csr_wr_data      = '0;
      reset            = 1'b1;
      quiet_sender     = 1'b0;
      cur_pos          = 0;
      values_sent      = 0;
      settings_used    = 0;
      repeat (6) @(negedge clock);
      reset = 1'b0;

      // ---- directed part ----
      // single digit: zero, largest fitting value, first overflow, full range
      set_position(0);
      send_value('0);
      send_value(VALUE_W'(9));
      send_value(VALUE_W'(10));
      send_value(VALUE_ALL_ONES);

      // nineteen digits: every 63-bit value fits, overflow never set
      set_position(18);
      send_value('0);
      send_value(VALUE_ALL_ONES);
      send_value(VALUE_W'(ten_to(18) - 64'd1));
      send_value(VALUE_W'(ten_to(18)));

      // position beyond the digit limit saturates to nineteen digits;
      // all-ones write data also toggles every register bit
      set_position(31);
      send_value(VALUE_ALL_ONES);
      send_value(VALUE_W'(64'd1234567890123456789));
      send_value('0);

      // two digits around the 100 boundary
      set_position(1);
      send_value(VALUE_W'(99));
      send_value(VALUE_W'(100));
      send_value(VALUE_W'(5));

      // first value past the limit also saturates
      set_position(MAX_DIGITS);
      send_value(VALUE_ALL_ONES);
      send_value(VALUE_W'(ten_to(18)));

      // ten digits around 10^10
      set_position(9);
      send_value(VALUE_W'(ten_to(10) - 64'd1));
      send_value(VALUE_W'(ten_to(10)));
      send_value(VALUE_W'(64'h2AAA_AAAA_AAAA_AAAA));

      // ---- random part ----
      // eight settings of 12 transactions each; the first three pin the
      // extremes, every third runs with no sender gaps at all
      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: pos = 0;
            1: pos = 18;
            2: pos = 31;
            default: pos = ($urandom_range(0, 3) == 0) ? $urandom_range(19, 31)
                                                      : $urandom_range(0, 18);
         endcase
         set_position(pos);
         quiet_sender = (phase % 3 == 2);
         repeat (12) send_value(random_value());
      end
      quiet_sender = 1'b0;

      // all requests are in: drain, then give stray strobes time to show up
      wait_idle();
      repeat (100) @(posedge clock);

      $display("Sent %0d values under %0d position settings (0 to 31).",
               values_sent, settings_used);
      $display("Checked %0d digit results.", digit_count);
      if (error_count == 0 && pending == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run (about 115 transactions, each
   // at its longest conversion and digit run plus the longest sender gap).
   initial begin
      #5ms;
      $display("Timeout waiting for the block.");
      $display("DONE: errors detected");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/core/b2d_pkg.sv
rtl/core/b2d_dabble_step.sv
rtl/core/binary_to_decimal_digits_top.sv
tb/sv/binary_to_decimal_digits_checker.sv
tb/sv/binary_to_decimal_digits_top_tb.sv
